// ===== rtl/vpht_pkg.sv =====
package vpht_pkg;

    // Field widths
    localparam int VID_W   = 31;
    localparam int DEG_W   = 32;
    localparam int PART_W  = 10;
    localparam int TOTAL_W = 48;
    localparam int GRAND_W = 60;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int MODE_W     = 3;
    localparam int NPART_W    = 11;
    localparam int NVERT_W    = 31;

    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTITIONS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES   = 2'd2;

    // Hash modes
    localparam logic [MODE_W-1:0] MODE_CYCLIC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RANGE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_JUMP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROTATE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SNAKE  = 3'd4;

    // Default partition store depth
    localparam int MAX_PARTS_DEF = 1024;

    // Jump hash constants
    localparam logic [63:0] JUMP_MULT        = 64'h27BB_2EE6_87B0_B0FD;
    localparam int          JUMP_SCALE_SHIFT = 31;
    localparam int          JUMP_KEY_SHIFT   = 33;

    // Shared divider: dividend covers (b+1) << 31 for up to 65536 partitions
    localparam int DVD_W = 48;
    localparam int DVS_W = 32;

    // Saturation limits
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [GRAND_W-1:0] GRAND_MAX = {GRAND_W{1'b1}};

    typedef struct packed {
        logic [MODE_W-1:0]  hash_mode;
        logic [NPART_W-1:0] num_partitions;
        logic [NVERT_W-1:0] num_vertices;
    } cfg_t;

endpackage

// ===== rtl/vpht_in_if.sv =====
interface vpht_in_if import vpht_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VID_W-1:0] vertex_id;
    logic [DEG_W-1:0] degree;

    modport source (output valid, vertex_id, degree, input ready);
    modport sink   (input valid, vertex_id, degree, output ready);
endinterface

// ===== rtl/vpht_out_if.sv =====
interface vpht_out_if import vpht_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PART_W-1:0]  partition;
    logic [TOTAL_W-1:0] partition_total;
    logic [TOTAL_W-1:0] max_total;
    logic [GRAND_W-1:0] grand_total;

    modport source (output valid, partition, partition_total, max_total, grand_total,
                    input ready);
    modport sink   (input valid, partition, partition_total, max_total, grand_total,
                    output ready);
endinterface

// ===== rtl/vertex_partition_hash_tally_top.sv =====
// Vertex partition tally. Each input beat carries a vertex id and its degree; the block
// maps the vertex to a partition (cyclic, range, jump consistent hash, rotation or snake,
// chosen by hash_mode) and adds the degree to that partition's saturating 48-bit total,
// kept in a MAX_PARTS-entry RAM, along with a running maximum and a saturating 60-bit
// grand total. One result beat comes out per input beat. Items are handled one at a
// time; the time per item is set by the shared radix-2 divider: cyclic and snake take
// one divider pass, range and rotation two, and jump hash one pass per hash iteration
// (roughly ln(P) + 1 iterations on average, at most P). After reset and after every
// configuration write the block clears all MAX_PARTS entries (1024 by default) of the
// totals RAM, one entry a cycle, and accepts no item meanwhile. Configuration writes to
// an index beyond the register list are ignored.
module vertex_partition_hash_tally_top import vpht_pkg::*; #(
    parameter int MAX_PARTS = MAX_PARTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    vpht_in_if.sink               in_ch,
    vpht_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PIDX_W = $clog2(MAX_PARTS);

    typedef enum logic [2:0] {
        T_CLEAR, T_IDLE, T_HASH, T_READ, T_UPD, T_OUT
    } tstate_t;

    tstate_t            state_reg;
    cfg_t               cfg_reg;
    logic [PIDX_W-1:0]  clr_cnt_reg;
    logic [DEG_W-1:0]   deg_reg;
    logic [PIDX_W-1:0]  part_reg;
    logic [TOTAL_W-1:0] tot_reg;
    logic [TOTAL_W-1:0] max_reg;
    logic [GRAND_W-1:0] sum_reg;

    logic               out_valid_reg;
    logic [PART_W-1:0]  out_part_reg;
    logic [TOTAL_W-1:0] out_tot_reg;
    logic [TOTAL_W-1:0] out_max_reg;
    logic [GRAND_W-1:0] out_sum_reg;

    logic               cfg_hit;
    logic               in_fire;
    logic               slot_free;
    logic               hash_done;
    logic [PIDX_W-1:0]  hash_part;

    logic               ram_we;
    logic [PIDX_W-1:0]  ram_waddr;
    logic [TOTAL_W-1:0] ram_wdata;
    logic [TOTAL_W-1:0] ram_rdata;

    logic [TOTAL_W:0]   tot_sum;
    logic [TOTAL_W-1:0] tot_next;
    logic [TOTAL_W-1:0] max_next;
    logic [GRAND_W:0]   grand_sum;
    logic [GRAND_W-1:0] sum_next;
    logic [31:0]        part_ext;

    assign cfg_hit   = cfg_we && (cfg_index == REG_HASH_MODE ||
                                  cfg_index == REG_NUM_PARTITIONS ||
                                  cfg_index == REG_NUM_VERTICES);
    assign in_ch.ready = (state_reg == T_IDLE);
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign slot_free = !out_valid_reg || out_ch.ready;

    vpht_hash #(.MAX_PARTS(MAX_PARTS)) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire),
        .cfg       (cfg_reg),
        .vertex_id (in_ch.vertex_id),
        .done      (hash_done),
        .part      (hash_part)
    );

    // Saturating adds on the totals read back from the RAM
    always_comb
    begin
        tot_sum   = (TOTAL_W + 1)'(ram_rdata) + (TOTAL_W + 1)'(deg_reg);
        tot_next  = (tot_sum > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
        max_next  = (tot_next > max_reg) ? tot_next : max_reg;
        grand_sum = (GRAND_W + 1)'(sum_reg) + (GRAND_W + 1)'(deg_reg);
        sum_next  = (grand_sum > (GRAND_W + 1)'(GRAND_MAX)) ? GRAND_MAX
                                                            : grand_sum[GRAND_W-1:0];
        part_ext  = 32'(part_reg);
    end

    // RAM write port: clearing sweep or write-back of the updated total
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = part_reg;
        ram_wdata = tot_next;
        case (state_reg)
            T_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            T_UPD:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // One item at a time, so a read never overlaps a pending write to the same entry
    vpht_ram #(.WIDTH(TOTAL_W), .DEPTH(MAX_PARTS)) u_totals (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == T_READ),
        .raddr (part_reg),
        .rdata (ram_rdata)
    );

    // Control sequence, configuration and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_CLEAR;
            cfg_reg       <= '{hash_mode: MODE_CYCLIC, num_partitions: NPART_W'(1),
                               num_vertices: NVERT_W'(1)};
            clr_cnt_reg   <= '0;
            deg_reg       <= '0;
            part_reg      <= '0;
            tot_reg       <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_part_reg  <= '0;
            out_tot_reg   <= '0;
            out_max_reg   <= '0;
            out_sum_reg   <= '0;
        end
        else
        begin
            // Hold the result beat until taken; load a fresh one from T_OUT
            if (state_reg == T_OUT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Register write: update and restart the clearing sweep
            if (cfg_hit)
            begin
                case (cfg_index)
                    REG_HASH_MODE:      cfg_reg.hash_mode      <= cfg_data[MODE_W-1:0];
                    REG_NUM_PARTITIONS: cfg_reg.num_partitions <= cfg_data[NPART_W-1:0];
                    REG_NUM_VERTICES:   cfg_reg.num_vertices   <= cfg_data[NVERT_W-1:0];
                    default:            cfg_reg                <= cfg_reg;
                endcase
                clr_cnt_reg <= '0;
                max_reg     <= '0;
                sum_reg     <= '0;
                state_reg   <= T_CLEAR;
            end
            else
            begin
                case (state_reg)
                    T_CLEAR:
                    begin
                        clr_cnt_reg <= clr_cnt_reg + PIDX_W'(1);
                        if (clr_cnt_reg == PIDX_W'(MAX_PARTS - 1))
                        begin
                            state_reg <= T_IDLE;
                        end
                    end
                    T_IDLE:
                    begin
                        if (in_fire)
                        begin
                            deg_reg   <= in_ch.degree;
                            state_reg <= T_HASH;
                        end
                    end
                    T_HASH:
                    begin
                        if (hash_done)
                        begin
                            part_reg  <= hash_part;
                            state_reg <= T_READ;
                        end
                    end
                    T_READ:
                    begin
                        state_reg <= T_UPD;
                    end
                    T_UPD:
                    begin
                        tot_reg   <= tot_next;
                        max_reg   <= max_next;
                        sum_reg   <= sum_next;
                        state_reg <= T_OUT;
                    end
                    T_OUT:
                    begin
                        if (slot_free)
                        begin
                            out_part_reg  <= part_ext[PART_W-1:0];
                            out_tot_reg   <= tot_reg;
                            out_max_reg   <= max_reg;
                            out_sum_reg   <= sum_reg;
                            state_reg     <= T_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= T_IDLE;
                    end
                endcase
            end
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.partition       = out_part_reg;
    assign out_ch.partition_total = out_tot_reg;
    assign out_ch.max_total       = out_max_reg;
    assign out_ch.grand_total     = out_sum_reg;

    // A reported partition total never exceeds the reported maximum
    a_total_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.partition_total <= out_ch.max_total))
        else $error("partition total above running maximum");

    // A register write restarts the clear with the tallies zeroed
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (state_reg == T_CLEAR && max_reg == '0 && sum_reg == '0 &&
                     clr_cnt_reg == '0))
        else $error("register write did not restart clearing");

    // No item is taken while the totals RAM is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_CLEAR) |-> !in_ch.ready)
        else $error("input accepted during clearing sweep");

endmodule

// ===== rtl/vpht_ram.sv =====
module vpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/vpht_div.sv =====
module vpht_div import vpht_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // Remainder always below the divisor once finished
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (remainder < dvs_reg))
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/vpht_hash.sv =====
module vpht_hash import vpht_pkg::*; #(
    parameter int MAX_PARTS = MAX_PARTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  cfg_t                         cfg,
    input  logic [VID_W-1:0]             vertex_id,
    output logic                         done,
    output logic [$clog2(MAX_PARTS)-1:0] part
);

    localparam int PIDX_W = $clog2(MAX_PARTS);
    localparam int PCNT_W = $clog2(MAX_PARTS + 1);

    typedef enum logic [3:0] {
        H_IDLE, H_D1_GO, H_D1_WAIT, H_D2_GO, H_D2_WAIT,
        H_J_CHK, H_J_M0, H_J_M1, H_J_M2, H_J_M3, H_J_GO, H_J_WAIT, H_DONE
    } hstate_t;

    hstate_t            state_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [PCNT_W-1:0]  p_reg;
    logic [NVERT_W-1:0] n_reg;
    logic [VID_W-1:0]   v_reg;
    logic [31:0]        tmp_reg;
    logic [63:0]        key_reg;
    logic [63:0]        pp_reg;
    logic [31:0]        cross_reg;
    logic [PIDX_W-1:0]  b_reg;
    logic [DVD_W-1:0]   j_reg;
    logic [PIDX_W-1:0]  part_reg;

    logic [31:0]        np_ext;
    logic [31:0]        p_sel;
    logic [PCNT_W-1:0]  p_eff;
    logic [NVERT_W-1:0] n_eff;

    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_quo;
    logic [DVS_W-1:0]   div_rem;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [DVD_W-1:0]   b_plus1;
    logic [31:0]        p_ext;

    // Clamp the partition and vertex counts
    always_comb
    begin
        np_ext = 32'(cfg.num_partitions);
        if (np_ext == 32'd0)
        begin
            p_sel = 32'd1;
        end
        else if (np_ext > 32'(MAX_PARTS))
        begin
            p_sel = 32'(MAX_PARTS);
        end
        else
        begin
            p_sel = np_ext;
        end
        p_eff = PCNT_W'(p_sel);
        n_eff = (cfg.num_vertices == '0) ? NVERT_W'(1) : cfg.num_vertices;
    end

    assign p_ext   = 32'(p_reg);
    assign b_plus1 = DVD_W'(b_reg) + DVD_W'(1);

    // Select divider operands per step
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = DVD_W'(v_reg);
        div_dvs   = p_ext;
        case (state_reg)
            H_D1_GO:
            begin
                div_start = 1'b1;
                if (mode_reg == MODE_RANGE)
                begin
                    div_dvd = DVD_W'(n_reg) + DVD_W'(p_reg) - DVD_W'(1);
                end
            end
            H_D2_GO:
            begin
                div_start = 1'b1;
                if (mode_reg == MODE_RANGE)
                begin
                    div_dvs = tmp_reg;
                end
                else
                begin
                    div_dvd = DVD_W'(v_reg) + DVD_W'(tmp_reg);
                end
            end
            H_J_GO:
            begin
                div_start = 1'b1;
                div_dvd   = b_plus1 << JUMP_SCALE_SHIFT;
                div_dvs   = DVS_W'(key_reg >> JUMP_KEY_SHIFT) + DVS_W'(1);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Shared 32x32 multiplier for the key update partial products
    always_comb
    begin
        case (state_reg)
            H_J_M1:
            begin
                mul_a = key_reg[31:0];
                mul_b = JUMP_MULT[63:32];
            end
            H_J_M2:
            begin
                mul_a = key_reg[63:32];
                mul_b = JUMP_MULT[31:0];
            end
            default:
            begin
                mul_a = key_reg[31:0];
                mul_b = JUMP_MULT[31:0];
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    vpht_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequence the selected mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            mode_reg  <= MODE_CYCLIC;
            p_reg     <= PCNT_W'(1);
            n_reg     <= NVERT_W'(1);
            v_reg     <= '0;
            tmp_reg   <= '0;
            key_reg   <= '0;
            pp_reg    <= '0;
            cross_reg <= '0;
            b_reg     <= '0;
            j_reg     <= '0;
            part_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg <= cfg.hash_mode;
                        p_reg    <= p_eff;
                        n_reg    <= n_eff;
                        v_reg    <= vertex_id;
                        key_reg  <= 64'(vertex_id);
                        b_reg    <= '0;
                        j_reg    <= '0;
                        if (cfg.hash_mode == MODE_JUMP)
                        begin
                            state_reg <= H_J_CHK;
                        end
                        else
                        begin
                            state_reg <= H_D1_GO;
                        end
                    end
                end
                H_D1_GO:
                begin
                    state_reg <= H_D1_WAIT;
                end
                H_D1_WAIT:
                begin
                    if (div_done)
                    begin
                        case (mode_reg)
                            MODE_RANGE, MODE_ROTATE:
                            begin
                                tmp_reg   <= div_quo[31:0];
                                state_reg <= H_D2_GO;
                            end
                            MODE_SNAKE:
                            begin
                                part_reg  <= PIDX_W'(p_ext - 32'd1 - div_rem);
                                state_reg <= H_DONE;
                            end
                            default:
                            begin
                                part_reg  <= PIDX_W'(div_rem);
                                state_reg <= H_DONE;
                            end
                        endcase
                    end
                end
                H_D2_GO:
                begin
                    state_reg <= H_D2_WAIT;
                end
                H_D2_WAIT:
                begin
                    if (div_done)
                    begin
                        if (mode_reg == MODE_RANGE)
                        begin
                            // Saturate a range index past the end
                            if (div_quo >= DVD_W'(p_reg))
                            begin
                                part_reg <= PIDX_W'(p_ext - 32'd1);
                            end
                            else
                            begin
                                part_reg <= PIDX_W'(div_quo);
                            end
                        end
                        else
                        begin
                            part_reg <= PIDX_W'(div_rem);
                        end
                        state_reg <= H_DONE;
                    end
                end
                H_J_CHK:
                begin
                    if (j_reg < DVD_W'(p_reg))
                    begin
                        b_reg     <= PIDX_W'(j_reg);
                        state_reg <= H_J_M0;
                    end
                    else
                    begin
                        part_reg  <= b_reg;
                        state_reg <= H_DONE;
                    end
                end
                H_J_M0:
                begin
                    pp_reg    <= mul_p;
                    state_reg <= H_J_M1;
                end
                H_J_M1:
                begin
                    cross_reg <= mul_p[31:0];
                    state_reg <= H_J_M2;
                end
                H_J_M2:
                begin
                    cross_reg <= cross_reg + mul_p[31:0];
                    state_reg <= H_J_M3;
                end
                H_J_M3:
                begin
                    key_reg   <= pp_reg + {cross_reg, 32'd0} + 64'd1;
                    state_reg <= H_J_GO;
                end
                H_J_GO:
                begin
                    state_reg <= H_J_WAIT;
                end
                H_J_WAIT:
                begin
                    if (div_done)
                    begin
                        j_reg     <= div_quo;
                        state_reg <= H_J_CHK;
                    end
                end
                H_DONE:
                begin
                    state_reg <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == H_DONE);
    assign part = part_reg;

    // Chosen partition stays inside the clamped count
    a_part_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(part) < p_ext))
        else $error("partition index beyond partition count");

endmodule

// ===== test/tb.sv =====
module tb;
    import vpht_pkg::*;

    // Spare codes that the block treats as cyclic or ignores
    localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
    localparam int                   NPARTS        = MAX_PARTS_DEF;

    typedef struct packed {
        logic [PART_W-1:0]  partition;
        logic [TOTAL_W-1:0] partition_total;
        logic [TOTAL_W-1:0] max_total;
        logic [GRAND_W-1:0] grand_total;
    } tally_res_t;

    // Partition tally predictor and store of expected beats
    class tally_scoreboard;
        logic [TOTAL_W-1:0] part_sum [NPARTS];
        logic [TOTAL_W-1:0] peak;
        logic [GRAND_W-1:0] deg_total;
        logic [MODE_W-1:0]  mode;
        logic [NPART_W-1:0] parts;
        logic [NVERT_W-1:0] verts;
        tally_res_t         pending [$];
        int                 errors;

        function new();
            mode   = MODE_CYCLIC;
            parts  = 1;
            verts  = 1;
            errors = 0;
            clear_tallies();
        endfunction

        function void clear_tallies();
            foreach (part_sum[i])
                part_sum[i] = '0;
            peak      = '0;
            deg_total = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HASH_MODE:      mode  = data[MODE_W-1:0];
                REG_NUM_PARTITIONS: parts = data[NPART_W-1:0];
                REG_NUM_VERTICES:   verts = data[NVERT_W-1:0];
                default:            return;
            endcase
            clear_tallies();
        endfunction

        function logic [63:0] jump_pick(logic [63:0] key, logic [63:0] p);
            logic [63:0] b;
            logic [63:0] j;
            logic [63:0] d;
            b = 0;
            j = 0;
            while (j < p)
            begin
                b   = j;
                key = key * JUMP_MULT + 64'd1;
                d   = (key >> JUMP_KEY_SHIFT) + 64'd1;
                j   = ((b + 64'd1) << JUMP_SCALE_SHIFT) / d;
            end
            return b;
        endfunction

        function logic [63:0] pick_partition(logic [63:0] v);
            logic [63:0] p;
            logic [63:0] n;
            logic [63:0] per;
            logic [63:0] idx;
            p = (parts == 0) ? 64'd1 : (parts > NPARTS) ? 64'(NPARTS) : 64'(parts);
            case (mode)
                MODE_RANGE:
                begin
                    n   = (verts == 0) ? 64'd1 : 64'(verts);
                    per = (n + p - 1) / p;
                    idx = v / per;
                    return (idx >= p) ? p - 1 : idx;
                end
                MODE_JUMP:   return jump_pick(v, p);
                MODE_ROTATE: return (v + v / p) % p;
                MODE_SNAKE:  return p - 1 - (v % p);
                default:     return v % p;
            endcase
        endfunction

        function void note_input(logic [VID_W-1:0] vid, logic [DEG_W-1:0] deg);
            logic [63:0] part;
            logic [63:0] t;
            logic [63:0] g;
            tally_res_t  r;
            part = pick_partition(64'(vid));
            if (part >= NPARTS)
                part = NPARTS - 1;
            t = 64'(part_sum[part]) + 64'(deg);
            if (t > 64'(TOTAL_MAX))
                t = 64'(TOTAL_MAX);
            part_sum[part] = t[TOTAL_W-1:0];
            if (t[TOTAL_W-1:0] > peak)
                peak = t[TOTAL_W-1:0];
            g = 64'(deg_total) + 64'(deg);
            if (g > 64'(GRAND_MAX))
                g = 64'(GRAND_MAX);
            deg_total = g[GRAND_W-1:0];
            r.partition       = part[PART_W-1:0];
            r.partition_total = t[TOTAL_W-1:0];
            r.max_total       = peak;
            r.grand_total     = deg_total;
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(tally_res_t got);
            tally_res_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected beat partition %0d", got.partition));
                return;
            end
            want = pending.pop_front();
            if (got.partition !== want.partition)
                report($sformatf("partition %0d, want %0d", got.partition, want.partition));
            if (got.partition_total !== want.partition_total)
                report($sformatf("partition_total %0d, want %0d",
                                 got.partition_total, want.partition_total));
            if (got.max_total !== want.max_total)
                report($sformatf("max_total %0d, want %0d", got.max_total, want.max_total));
            if (got.grand_total !== want.grand_total)
                report($sformatf("grand_total %0d, want %0d",
                                 got.grand_total, want.grand_total));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    quiet;
    int                    stall_left;
    tally_scoreboard       sb;

    vpht_in_if  in_ch ();
    vpht_out_if out_ch ();

    vertex_partition_hash_tally_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #(8 * 8000000);
        $display("status: fail");
        $finish;
    end

    // Drive output ready with random stall bursts
    initial
    begin
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Check each accepted result beat before the edge that takes it
    initial
    begin
        tally_res_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.partition       = out_ch.partition;
                got.partition_total = out_ch.partition_total;
                got.max_total       = out_ch.max_total;
                got.grand_total     = out_ch.grand_total;
                sb.check_result(got);
            end
        end
    end

    // Send one beat; optionally idle a burst first
    task send_item(logic [VID_W-1:0] vid, logic [DEG_W-1:0] deg);
        bit taken;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.vertex_id <= vid;
        in_ch.degree    <= deg;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ch.ready;
            if (taken)
                sb.note_input(vid, deg);
            @(posedge clk);
        end
    endtask

    // Hold until every expected beat is back
    task drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task setup(logic [MODE_W-1:0] mode, logic [NPART_W-1:0] p, logic [NVERT_W-1:0] n);
        drain();
        write_reg(REG_HASH_MODE, CFG_DATA_W'(mode));
        write_reg(REG_NUM_PARTITIONS, CFG_DATA_W'(p));
        write_reg(REG_NUM_VERTICES, CFG_DATA_W'(n));
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function logic [VID_W-1:0] rand_vid();
        case ($urandom_range(0, 3))
            0:       return VID_W'($urandom_range(0, 2 * NPARTS + 5));
            1:       return VID_W'($urandom);
            2:       return VID_W'(sb.verts) + VID_W'($urandom_range(0, 4)) - VID_W'(2);
            default: return {VID_W{1'b1}} - VID_W'($urandom_range(0, 3));
        endcase
    endfunction

    function logic [DEG_W-1:0] rand_deg();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return {DEG_W{1'b1}};
            2:       return DEG_W'($urandom_range(0, 100));
            default: return DEG_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [MODE_W-1:0]  mode;
        logic [NPART_W-1:0] p;
        logic [NVERT_W-1:0] n;
        sb = new();
        quiet = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.vertex_id <= '0;
        in_ch.degree <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config, field extremes, each mode and the odd settings
        send_item('0, '0);
        send_item({VID_W{1'b1}}, {DEG_W{1'b1}});
        send_item(VID_W'(77), {DEG_W{1'b1}});
        setup(MODE_RANGE, NPART_W'(4), NVERT_W'(10));
        send_item(VID_W'(0), DEG_W'(5));
        send_item(VID_W'(9), DEG_W'(6));
        send_item(VID_W'(10), DEG_W'(7));
        send_item({VID_W{1'b1}}, DEG_W'(8));
        setup(MODE_JUMP, NPART_W'(NPARTS), NVERT_W'(1));
        send_item(VID_W'(0), DEG_W'(1));
        send_item({VID_W{1'b1}}, DEG_W'(2));
        send_item(VID_W'(12345), DEG_W'(3));
        setup(MODE_ROTATE, NPART_W'(7), NVERT_W'(1));
        send_item(VID_W'(6), DEG_W'(1));
        send_item(VID_W'(7), DEG_W'(1));
        send_item(VID_W'(49), DEG_W'(1));
        setup(MODE_SNAKE, NPART_W'(5), {NVERT_W{1'b1}});
        send_item(VID_W'(0), DEG_W'(9));
        send_item(VID_W'(4), DEG_W'(9));
        setup(MODE_SPARE_HI, NPART_W'(0), NVERT_W'(0));
        send_item(VID_W'(5), DEG_W'(4));
        setup(MODE_RANGE, NPART_W'(0), NVERT_W'(0));
        send_item(VID_W'(3), DEG_W'(4));
        setup(MODE_SPARE_LO, {NPART_W{1'b1}}, NVERT_W'(1));
        send_item(VID_W'(1023), DEG_W'(1));
        send_item(VID_W'(2000), DEG_W'(1));

        // Random phases; mostly small partition counts
        for (int ph = 0; ph < 12; ph++)
        begin
            mode = MODE_W'(ph % 8);
            case ($urandom_range(0, 5))
                0:       p = ($urandom_range(0, 1) == 0) ? NPART_W'(NPARTS) : {NPART_W{1'b1}};
                1:       p = NPART_W'($urandom_range(0, 1));
                2:       p = NPART_W'($urandom_range(1, 100));
                default: p = NPART_W'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 3))
                0:       n = NVERT_W'($urandom_range(0, 1));
                1:       n = NVERT_W'($urandom);
                default: n = NVERT_W'($urandom_range(1, 4000));
            endcase
            quiet = (ph >= 10);
            setup(mode, p, n);
            for (int k = 0; k < 82; k++)
            begin
                if (k == 40 && ph == 3)
                    drain();
                send_item(rand_vid(), rand_deg());
            end
        end

        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/vpht_pkg.sv
rtl/vpht_in_if.sv
rtl/vpht_out_if.sv
rtl/vpht_ram.sv
rtl/vpht_div.sv
rtl/vpht_hash.sv
rtl/vertex_partition_hash_tally_top.sv
test/tb.sv
